@@ hw/rtl/lrar_pkg.sv @@
// ----------------------------------------------------------------------------
// lrar_pkg
// Shared types and constants of the ranged aligned Lehmer random source.
// ----------------------------------------------------------------------------
package lrar_pkg;

  // Generator step constants (Schrage decomposition of 16807*x mod 2^31-1).
  localparam int LCG_MULT    = 16807;
  localparam int LCG_QUOT    = 127773;
  localparam int LCG_REM     = 2836;
  localparam int LCG_MOD     = 32'h7fff_ffff;
  localparam int ZERO_SUBST  = 123459876;
  localparam int STATE_RESET = 937186357;

  // Command sequencing limits.
  localparam int WARMUP_ROUNDS = 50;
  localparam int MAX_TRIES     = 16;
  localparam int WARM_W        = 8;
  localparam int TRY_W         = $clog2(MAX_TRIES + 1);

  // Datapath widths.
  localparam int STATE_W = 32;
  localparam int VALUE_W = 64;
  localparam int BITS_W  = $clog2(STATE_W);

  // Command codes.
  localparam logic CMD_RESEED = 1'b0;
  localparam logic CMD_DRAW   = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [31:0] seed_value;
    logic [63:0] range_low;
    logic [63:0] range_high;
    logic [5:0]  align_log2;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [1:0]  status;
  } out_res_t;

  // Control of the generator step unit.
  typedef struct packed {
    logic load;
    logic step;
  } lcg_ctl_t;

endpackage

@@ hw/rtl/lrar_lcg.sv @@
// ----------------------------------------------------------------------------
// lrar_lcg
// Generator state and a bit-serial step unit: restoring division by the
// Schrage quotient constant, one quotient bit per cycle, then multiply and fix-up.
// ----------------------------------------------------------------------------
module lrar_lcg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lrar_pkg::lcg_ctl_t     ctl,
  input  logic [31:0]            seed,
  output logic                   done,
  output logic [31:0]            state
);
  import lrar_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_DIV  = 4'b0010,
    L_MUL  = 4'b0100,
    L_FIX  = 4'b1000
  } lcg_state_t;

  lcg_state_t          fsm_r;
  logic [STATE_W-1:0]  state_r;
  logic [STATE_W-1:0]  x_r;
  logic [16:0]         rem_r;
  logic [15:0]         quo_r;
  logic [BITS_W-1:0]   cnt_r;
  logic [31:0]         p1_r;
  logic [27:0]         p2_r;
  logic                done_r;

  logic [17:0]         trial;
  logic                ge;
  logic [32:0]         t_raw;
  logic [32:0]         t_fix;

  assign trial = {rem_r, x_r[STATE_W-1]};
  assign ge    = (trial >= 18'(LCG_QUOT));
  assign t_raw = {1'b0, p1_r} - {5'b0, p2_r};
  assign t_fix = t_raw[32] ? (t_raw + 33'(LCG_MOD)) : t_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r   <= L_IDLE;
      state_r <= STATE_W'(STATE_RESET);
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (fsm_r)
        L_IDLE: begin
          if (ctl.load) begin
            state_r <= seed;
          end else if (ctl.step) begin
            // A zero state is replaced before stepping.
            x_r   <= (state_r == '0) ? STATE_W'(ZERO_SUBST) : state_r;
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= '0;
            fsm_r <= L_DIV;
          end
        end
        L_DIV: begin
          rem_r <= ge ? 17'(trial - 18'(LCG_QUOT)) : trial[16:0];
          quo_r <= {quo_r[14:0], ge};
          x_r   <= {x_r[STATE_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == BITS_W'(STATE_W - 1)) begin
            fsm_r <= L_MUL;
          end
        end
        L_MUL: begin
          p1_r  <= 32'(rem_r) * 32'(LCG_MULT);
          p2_r  <= 28'(quo_r) * 28'(LCG_REM);
          fsm_r <= L_FIX;
        end
        L_FIX: begin
          state_r <= t_fix[31:0];
          done_r  <= 1'b1;
          fsm_r   <= L_IDLE;
        end
        default: begin
          fsm_r <= L_IDLE;
        end
      endcase
    end
  end

  assign done  = done_r;
  assign state = state_r;

endmodule

@@ hw/rtl/lrar_moddiv.sv @@
// ----------------------------------------------------------------------------
// lrar_moddiv
// Restoring remainder unit: a 32-bit dividend shifted in one bit per cycle
// against a 64-bit divisor.
// ----------------------------------------------------------------------------
module lrar_moddiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] rem
);
  import lrar_pkg::*;

  logic                run_r;
  logic                done_r;
  logic [STATE_W-1:0]  dvd_r;
  logic [VALUE_W-1:0]  dvs_r;
  logic [VALUE_W-1:0]  rem_r;
  logic [BITS_W-1:0]   cnt_r;

  logic [VALUE_W:0]    trial;
  logic                ge;

  assign trial = {rem_r, dvd_r[STATE_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (run_r) begin
        rem_r <= ge ? VALUE_W'(trial - {1'b0, dvs_r}) : trial[VALUE_W-1:0];
        dvd_r <= {dvd_r[STATE_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == BITS_W'(STATE_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (go) begin
        dvd_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ hw/rtl/lehmer_ranged_aligned_random_top.sv @@
// ----------------------------------------------------------------------------
// lehmer_ranged_aligned_random_top
// Multiplicative congruential random source with ranged, aligned draws.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on in_req when start is high and busy is low. A
//   reseed request loads seed_value into the generator and runs the warm-up
//   steps; a draw request returns a value in [range_low, range_high) with
//   its low align_log2 bits cleared.
//   Exactly one result per request appears on out_res for a single cycle,
//   marked by out_valid. The receiver cannot stall; it must take the result
//   in that cycle. busy drops in the same cycle out_valid is shown, so the
//   next request may be issued right away.
// Sequence:
//   One generator step is the bit-serial division by the Schrage quotient
//   constant, then the multiply and the fix-up. Reseed runs 50 warm-up
//   rounds of one generator step each. A draw runs attempts of step,
//   remainder unit, add and compare, at most MAX_TRIES attempts. An empty
//   range answers without any attempt.
// Reset:
//   rst_n is synchronous and active low. It returns the generator to its
//   power-on state and drops any request in flight without a result.
// ----------------------------------------------------------------------------
module lehmer_ranged_aligned_random_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lrar_pkg::in_req_t   in_req,
  output logic                out_valid,
  output lrar_pkg::out_res_t  out_res
);
  import lrar_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_WARM  = 7'b0000010,
    S_WWAIT = 7'b0000100,
    S_SPAN  = 7'b0001000,
    S_GEN   = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_CMP   = 7'b1000000
  } top_state_t;

  top_state_t          state_r, state_nxt;
  logic [WARM_W-1:0]   warm_r, warm_nxt;
  logic [TRY_W-1:0]    try_r, try_nxt;
  logic [VALUE_W-1:0]  low_r, low_nxt;
  logic [VALUE_W-1:0]  span_r, span_nxt;
  logic [VALUE_W-1:0]  mask_r, mask_nxt;
  logic [VALUE_W-1:0]  v_r, v_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_res_t            res_r, res_nxt;

  lcg_ctl_t            lcg_ctl;
  logic                lcg_done;
  logic [STATE_W-1:0]  gen_state;
  logic                mod_go;
  logic                mod_done;
  logic [VALUE_W-1:0]  mod_rem;
  logic [VALUE_W-1:0]  aligned;
  logic                accept;

  lrar_lcg u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lcg_ctl),
    .seed  (in_req.seed_value),
    .done  (lcg_done),
    .state (gen_state)
  );

  lrar_moddiv u_moddiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (mod_go),
    .dividend (gen_state),
    .divisor  (span_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign aligned = v_r & mask_r;

  always_comb begin
    state_nxt     = state_r;
    warm_nxt      = warm_r;
    try_nxt       = try_r;
    low_nxt       = low_r;
    span_nxt      = span_r;
    mask_nxt      = mask_r;
    v_nxt         = v_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    lcg_ctl       = '0;
    mod_go        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.cmd == CMD_RESEED) begin
            lcg_ctl.load = 1'b1;
            warm_nxt     = '0;
            state_nxt    = S_WARM;
          end else begin
            low_nxt   = in_req.range_low;
            span_nxt  = in_req.range_high - in_req.range_low;
            mask_nxt  = {VALUE_W{1'b1}} << in_req.align_log2;
            state_nxt = S_SPAN;
          end
        end
      end
      S_WARM: begin
        if (warm_r == WARM_W'(WARMUP_ROUNDS)) begin
          res_nxt.result_value = VALUE_W'(gen_state);
          res_nxt.status       = STATUS_OK;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end else begin
          lcg_ctl.step = 1'b1;
          state_nxt    = S_WWAIT;
        end
      end
      S_WWAIT: begin
        if (lcg_done) begin
          warm_nxt  = warm_r + 1'b1;
          state_nxt = S_WARM;
        end
      end
      S_SPAN: begin
        // An empty range answers at once and leaves the generator alone.
        if (span_r == '0) begin
          res_nxt.result_value = '0;
          res_nxt.status       = STATUS_EMPTY;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end else begin
          try_nxt      = '0;
          lcg_ctl.step = 1'b1;
          state_nxt    = S_GEN;
        end
      end
      S_GEN: begin
        if (lcg_done) begin
          mod_go    = 1'b1;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          v_nxt     = mod_rem + low_r;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (aligned >= low_r) begin
          res_nxt.result_value = aligned;
          res_nxt.status       = STATUS_OK;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end else if (try_r == TRY_W'(MAX_TRIES - 1)) begin
          // Alignment pushed every attempt below the lower bound.
          res_nxt.result_value = '0;
          res_nxt.status       = STATUS_EXHAUSTED;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end else begin
          try_nxt      = try_r + 1'b1;
          lcg_ctl.step = 1'b1;
          state_nxt    = S_GEN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      warm_r      <= '0;
      try_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      warm_r      <= warm_nxt;
      try_r       <= try_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    span_r <= span_nxt;
    mask_r <= mask_nxt;
    v_r    <= v_nxt;
    res_r  <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

@@ hw/rtl/lrar_checker.sv @@
// ----------------------------------------------------------------------------
// lrar_checker
// Port-level checks of the random source, bound to the top level.
// ----------------------------------------------------------------------------
module lrar_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input lrar_pkg::in_req_t   in_req,
  input logic                out_valid,
  input lrar_pkg::out_res_t  out_res
);
  import lrar_pkg::*;

  // A taken request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // Results never come in adjacent cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // The end of a request is always marked by its result.
  a_fell_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // Failure codes carry a zero value and no undefined code appears.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_res.status == STATUS_EMPTY ||
                   out_res.status == STATUS_EXHAUSTED))
      |-> (out_res.result_value == '0))
    else $error("failure status with nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.status == STATUS_OK || out_res.status == STATUS_EMPTY ||
                   out_res.status == STATUS_EXHAUSTED))
    else $error("undefined status code");

endmodule

bind lehmer_ranged_aligned_random_top lrar_checker u_lrar_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_res   (out_res)
);
